>>> hdl/vonm_pkg.sv
// Shared constants, action and status codes for the voxel occupancy mask block.
package vonm_pkg;

   localparam int unsigned GRID_DIM_DEF = 16;

   localparam int unsigned ACTION_W = 3;
   localparam int unsigned COORD_W  = 8;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned MASK_W   = 27;

   localparam int unsigned REQ_TDATA_W = 32;
   localparam int unsigned RSP_TDATA_W = 32;

   localparam logic [ACTION_W-1:0] ACT_TEST  = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_SET   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_FACE  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_FULL  = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_COADJ = 3'd5;

   localparam logic [STATUS_W-1:0] ST_CLEAR   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_SET     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd2;

endpackage

>>> hdl/vonm_col_ram.sv
// Column word memory: one write port and one read port with registered read data.
module vonm_col_ram #(
   parameter int unsigned DEPTH  = vonm_pkg::GRID_DIM_DEF * vonm_pkg::GRID_DIM_DEF,
   parameter int unsigned WIDTH  = vonm_pkg::GRID_DIM_DEF,
   localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/vonm_mask_calc.sv
// Builds the face, full and co-adjacency masks from the gathered 3x3x3 cell bits.
module vonm_mask_calc (
   input  logic [vonm_pkg::ACTION_W-1:0] action,
   input  logic [vonm_pkg::MASK_W-1:0]   cube,
   output logic [vonm_pkg::MASK_W-1:0]   neighbour_mask
);

   logic [vonm_pkg::MASK_W-1:0] coadj;
   logic [5:0]                  face;

   // Cube bit (a,b,c) sits at a*9+b*3+c with a,b,c = offset+1.
   always_comb begin
      logic [4:0] i;
      logic       keep;
      coadj = '0;
      for (int a = 0; a < 3; a++) begin
         for (int b = 0; b < 3; b++) begin
            for (int c = 0; c < 3; c++) begin
               i    = 5'(a * 9 + b * 3 + c);
               keep = cube[i];
               if (a != 1) keep = keep & cube[5'(9 + b * 3 + c)];
               if (b != 1) keep = keep & cube[5'(a * 9 + 3 + c)];
               if (c != 1) keep = keep & cube[5'(a * 9 + b * 3 + 1)];
               if (a != 1 || b != 1) keep = keep & cube[5'(12 + c)];
               if (a != 1 || c != 1) keep = keep & cube[5'(9 + b * 3 + 1)];
               if (b != 1 || c != 1) keep = keep & cube[5'(a * 9 + 4)];
               coadj[i] = keep;
            end
         end
      end
   end

   // Face order: y-1, x-1, z-1, z+1, x+1, y+1.
   assign face = {cube[16], cube[22], cube[14], cube[12], cube[4], cube[10]};

   always_comb begin
      unique case (action)
         vonm_pkg::ACT_FACE:  neighbour_mask = {21'd0, face};
         vonm_pkg::ACT_FULL:  neighbour_mask = cube;
         vonm_pkg::ACT_COADJ: neighbour_mask = coadj;
         default:             neighbour_mask = '0;
      endcase
   end

endmodule

>>> hdl/voxel_occupancy_neighbour_mask.sv
// Top level: voxel occupancy bitmap with test, set, clear and neighbourhood masks.
// Each item runs a read step (one column for test, set and clear, nine for the mask
// actions), a drain step, a write-back for an in-grid set or clear and a done step
// that waits for the response slot; one item is worked on at a time, so no request
// beat is taken until the response is loaded. Reset is synchronous; afterwards the
// GRID_DIM*GRID_DIM columns (256 by default) are zeroed one per cycle, no beat taken.
module voxel_occupancy_neighbour_mask #(
   parameter int unsigned GRID_DIM = vonm_pkg::GRID_DIM_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [2:0] action, [10:3] x_coord, [18:11] y_coord, [26:19] z_coord, rest zero
   input  logic [vonm_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [1:0] flag_status, [28:2] neighbour_mask, rest zero
   output logic [vonm_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   localparam int unsigned IDX_W  = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
   localparam int unsigned DEPTH  = GRID_DIM * GRID_DIM;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam logic [3:0]  FIRST_K  = 4'd0;
   localparam logic [3:0]  CENTER_K = 4'd4;
   localparam logic [3:0]  LAST_K   = 4'd8;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_READ, S_DRAIN, S_WRITE, S_DONE
   } state_type;

   // A coordinate carried with one extra bit is inside when it is not
   // negative and below the grid size.
   function automatic logic coord_ok(input logic [8:0] c);
      return !c[8] && (c[7:0] < 8'(GRID_DIM));
   endfunction

   state_type                          state_ff, state_in;
   logic [ADDR_W-1:0]                  clr_addr_ff, clr_addr_in;
   logic [3:0]                         k_ff, k_in;
   logic                               cap_valid_ff, cap_valid_in;
   logic                               cap_ok_ff, cap_ok_in;
   logic [3:0]                         cap_k_ff, cap_k_in;
   logic [vonm_pkg::ACTION_W-1:0]      act_ff, act_in;
   logic [7:0]                         x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [vonm_pkg::MASK_W-1:0]        cube_ff, cube_in;
   logic [GRID_DIM-1:0]                center_word_ff, center_word_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [vonm_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [vonm_pkg::MASK_W-1:0]        rsp_mask_ff, rsp_mask_in;

   logic [1:0]                         kx, ky;
   logic [3:0]                         k_rem;
   logic [8:0]                         nx, ny;
   logic                               col_ok;
   logic [ADDR_W-1:0]                  col_addr;
   logic                               center_ok;
   logic                               is_mask_act, is_write_act, new_is_mask;
   logic [GRID_DIM-1:0]                cap_word, z_bit, new_word;
   logic [2:0]                         cap_bits;
   logic [vonm_pkg::MASK_W-1:0]        mask_calc;
   logic                               req_fire, rsp_load;

   logic                               ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]                  ram_wr_addr;
   logic [GRID_DIM-1:0]                ram_wr_data, ram_rd_data;

   // Neighbor column for read step k: dx = k/3 - 1, dy = k%3 - 1.
   always_comb begin
      if (k_ff >= 4'd6) begin
         kx = 2'd2;
      end else if (k_ff >= 4'd3) begin
         kx = 2'd1;
      end else begin
         kx = 2'd0;
      end
      k_rem = k_ff - ((kx == 2'd2) ? 4'd6 : ((kx == 2'd1) ? 4'd3 : 4'd0));
      ky    = k_rem[1:0];
      nx    = {x_ff[7], x_ff} + {7'd0, kx} - 9'd1;
      ny    = {y_ff[7], y_ff} + {7'd0, ky} - 9'd1;
   end

   assign col_ok   = coord_ok(nx) && coord_ok(ny);
   assign col_addr = ADDR_W'(nx[IDX_W-1:0]) * ADDR_W'(GRID_DIM) + ADDR_W'(ny[IDX_W-1:0]);
   assign center_ok = coord_ok({x_ff[7], x_ff}) && coord_ok({y_ff[7], y_ff})
                      && coord_ok({z_ff[7], z_ff});

   assign is_mask_act  = (act_ff == vonm_pkg::ACT_FACE) || (act_ff == vonm_pkg::ACT_FULL)
                         || (act_ff == vonm_pkg::ACT_COADJ);
   assign is_write_act = (act_ff == vonm_pkg::ACT_SET) || (act_ff == vonm_pkg::ACT_CLEAR);
   assign new_is_mask  = (req_tdata[2:0] == vonm_pkg::ACT_FACE)
                         || (req_tdata[2:0] == vonm_pkg::ACT_FULL)
                         || (req_tdata[2:0] == vonm_pkg::ACT_COADJ);

   // Read data lands in the cycle after the read; columns off the grid read as empty.
   assign cap_word = cap_ok_ff ? ram_rd_data : '0;

   always_comb begin
      logic [8:0] nz;
      for (int j = 0; j < 3; j++) begin
         nz          = {z_ff[7], z_ff} + 9'(j) - 9'd1;
         cap_bits[j] = coord_ok(nz) && cap_word[nz[IDX_W-1:0]];
      end
   end

   assign z_bit    = GRID_DIM'(1) << z_ff[IDX_W-1:0];
   assign new_word = (act_ff == vonm_pkg::ACT_SET) ? (center_word_ff | z_bit)
                                                   : (center_word_ff & ~z_bit);

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      k_in           = k_ff;
      cap_valid_in   = 1'b0;
      cap_ok_in      = col_ok;
      cap_k_in       = k_ff;
      act_in         = act_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      z_in           = z_ff;
      cube_in        = cube_ff;
      center_word_in = center_word_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_mask_in    = rsp_mask_ff;

      if (cap_valid_ff) begin
         cube_in[5'(cap_k_ff) * 5'd3 +: 3] = cap_bits;
         if (cap_k_ff == CENTER_K) begin
            center_word_in = cap_word;
         end
      end

      unique case (state_ff)
         S_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               act_in   = req_tdata[2:0];
               x_in     = req_tdata[10:3];
               y_in     = req_tdata[18:11];
               z_in     = req_tdata[26:19];
               cube_in  = '0;
               k_in     = new_is_mask ? FIRST_K : CENTER_K;
               state_in = S_READ;
            end
         end
         S_READ: begin
            cap_valid_in = 1'b1;
            if (k_ff == LAST_K || !is_mask_act) begin
               state_in = S_DRAIN;
            end else begin
               k_in = k_ff + 4'd1;
            end
         end
         S_DRAIN: begin
            k_in     = CENTER_K;
            state_in = (is_write_act && center_ok) ? S_WRITE : S_DONE;
         end
         S_WRITE: begin
            cube_in[13] = (act_ff == vonm_pkg::ACT_SET);
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = !center_ok ? vonm_pkg::ST_OUTSIDE
                             : (cube_ff[13] ? vonm_pkg::ST_SET : vonm_pkg::ST_CLEAR);
               rsp_mask_in   = mask_calc;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         cap_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         cap_valid_ff <= cap_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff           <= k_in;
      cap_ok_ff      <= cap_ok_in;
      cap_k_ff       <= cap_k_in;
      act_ff         <= act_in;
      x_ff           <= x_in;
      y_ff           <= y_in;
      z_ff           <= z_in;
      cube_ff        <= cube_in;
      center_word_ff <= center_word_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_mask_ff    <= rsp_mask_in;
   end

   // Reads and writes never share a cycle, so a write-back is always seen by
   // the next item's reads without forwarding.
   assign ram_rd_en   = (state_ff == S_READ) && col_ok;
   assign ram_wr_en   = (state_ff == S_CLEAR) || (state_ff == S_WRITE);
   assign ram_wr_addr = (state_ff == S_CLEAR) ? clr_addr_ff : col_addr;
   assign ram_wr_data = (state_ff == S_CLEAR) ? '0 : new_word;

   vonm_col_ram #(
      .DEPTH (DEPTH),
      .WIDTH (GRID_DIM)
   ) u_col_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (col_addr),
      .rd_data (ram_rd_data)
   );

   vonm_mask_calc u_mask_calc (
      .action         (act_ff),
      .cube           (cube_ff),
      .neighbour_mask (mask_calc)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_mask_ff, rsp_status_ff};

`ifndef ASSERT_OFF
   a_no_rd_wr_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_rd_en && ram_wr_en))
      else $error("column read and write in the same cycle");

   a_capture_follows_read: assert property (@(posedge clock) disable iff (reset)
      (cap_valid_ff && cap_ok_ff) |-> $past(ram_rd_en))
      else $error("column captured without a read one cycle earlier");

   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second request beat taken while an item is in flight");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_DONE))
      else $error("response raised outside the result step");
`endif

endmodule
